// ===== src/plp3_pkg.sv =====
// Shared widths, types and helpers for the 3D point-to-line projection block.
// Used by plp3_div, point_line_projection_3d and plp3_checker; depends on nothing.
package plp3_pkg;

  // coordinate and intermediate widths
  localparam int COORD_W = 32;             // Q16.16 coordinate
  localparam int DIFF_W  = COORD_W + 1;    // B - A, P - A
  localparam int MAG_W   = COORD_W;        // magnitude of a difference
  localparam int SQ_W    = 2 * MAG_W;      // one product of magnitudes
  localparam int DEN_W   = SQ_W + 2;       // u.u, sum of three squares
  localparam int NUM_W   = SQ_W + 3;       // u.m, signed sum of three
  localparam int HALF_W  = DEN_W / 2;      // split of |num| for the multiply
  localparam int PP_W    = HALF_W + MAG_W; // one partial product
  localparam int PROD_W  = DEN_W + MAG_W;  // |num| * |u_i|
  localparam int Q_W     = 34;             // quotient bits, bounded by |P - A|
  localparam int RES_W   = Q_W + 2;        // A +/- rounded quotient
  localparam int LANES   = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  // what travels alongside the division
  typedef struct packed {
    coord_t             ax;
    coord_t             ay;
    coord_t             az;
    logic [LANES-1:0]   uneg;
    logic               nneg;
    logic               degen;
  } side_t;

  // magnitude of a difference, always below 2^32
  function automatic logic [MAG_W-1:0] diff_mag(input diff_t v);
    diff_t n;
    n = -v;
    return v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

// ===== src/plp3_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. Depends on plp3_pkg for widths and the sideband type.
module plp3_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [plp3_pkg::PROD_W-1:0]          in_prod [plp3_pkg::LANES],
  input  logic [plp3_pkg::DEN_W-1:0]           in_den,
  input  plp3_pkg::side_t                      in_side,
  output logic                                 out_vld,
  output logic [plp3_pkg::Q_W-1:0]             out_q   [plp3_pkg::LANES],
  output logic [plp3_pkg::DEN_W-1:0]           out_rem [plp3_pkg::LANES],
  output logic [plp3_pkg::DEN_W-1:0]           out_den,
  output plp3_pkg::side_t                      out_side
);

  localparam int N  = plp3_pkg::Q_W;
  localparam int DW = plp3_pkg::DEN_W;
  localparam int L  = plp3_pkg::LANES;

  logic [DW-1:0]         rem_r  [N][L];
  logic [N-1:0]          low_r  [N][L];
  logic [N-1:0]          q_r    [N][L];
  logic [DW-1:0]         den_r  [N];
  plp3_pkg::side_t       side_r [N];
  logic                  vld_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [DW-1:0]   rem_in  [L];
    logic [N-1:0]    low_in  [L];
    logic [N-1:0]    q_in    [L];
    logic [DW-1:0]   den_in;
    plp3_pkg::side_t side_in;
    logic            vld_in;
    logic [DW:0]     trial   [L];
    logic            take    [L];
    logic [DW-1:0]   rem_nxt [L];
    logic [N-1:0]    low_nxt [L];
    logic [N-1:0]    q_nxt   [L];

    // pick the stage input: the ports for the first step, else the step before
    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < L; j++) begin
          rem_in[j] = DW'(in_prod[j][plp3_pkg::PROD_W-1:N]);
          low_in[j] = in_prod[j][N-1:0];
          q_in[j]   = '0;
        end
        den_in  = in_den;
        side_in = in_side;
        vld_in  = in_vld;
      end
    end else begin : g_next
      always_comb begin
        for (int j = 0; j < L; j++) begin
          rem_in[j] = rem_r[k-1][j];
          low_in[j] = low_r[k-1][j];
          q_in[j]   = q_r[k-1][j];
        end
        den_in  = den_r[k-1];
        side_in = side_r[k-1];
        vld_in  = vld_r[k-1];
      end
    end

    // shift in one dividend bit, subtract where it fits
    always_comb begin
      for (int j = 0; j < L; j++) begin
        trial[j]   = {rem_in[j], low_in[j][N-1]};
        take[j]    = trial[j] >= {1'b0, den_in};
        rem_nxt[j] = take[j] ? DW'(trial[j] - {1'b0, den_in}) : trial[j][DW-1:0];
        low_nxt[j] = {low_in[j][N-2:0], 1'b0};
        q_nxt[j]   = {q_in[j][N-2:0], take[j]};
      end
    end

    // hold the step register while the pipeline is stalled
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < L; j++) begin
          rem_r[k][j] <= rem_nxt[j];
          low_r[k][j] <= low_nxt[j];
          q_r[k][j]   <= q_nxt[j];
        end
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_q    = q_r[N-1];
  assign out_rem  = rem_r[N-1];
  assign out_den  = den_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== src/point_line_projection_3d.sv =====
// Point-to-line projection in 3D: foot of the perpendicular from P onto AB.
// Depends on plp3_pkg and plp3_div.
//
// Each beat of P, A and B (signed Q16.16) gives one result beat with
// A + u*(u.m)/(u.u), u = B - A, m = P - A, rounded to nearest with ties away
// from zero and saturated to 32 bits (overflow flags it). When A equals B the
// result is A with degenerate set. Throughput is one beat per cycle unless a
// stall on the result side freezes the whole pipeline. It has five stages of
// difference, product, sum and partial-product work, 34 stages of the quotient
// divider (one bit each) and the output register.
module point_line_projection_3d (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  plp3_pkg::coord_t        in_point_x,
  input  plp3_pkg::coord_t        in_point_y,
  input  plp3_pkg::coord_t        in_point_z,
  input  plp3_pkg::coord_t        in_line_a_x,
  input  plp3_pkg::coord_t        in_line_a_y,
  input  plp3_pkg::coord_t        in_line_a_z,
  input  plp3_pkg::coord_t        in_line_b_x,
  input  plp3_pkg::coord_t        in_line_b_y,
  input  plp3_pkg::coord_t        in_line_b_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output plp3_pkg::coord_t        out_proj_x,
  output plp3_pkg::coord_t        out_proj_y,
  output plp3_pkg::coord_t        out_proj_z,
  output logic                    out_degenerate,
  output logic                    out_overflow
);

  localparam int L = plp3_pkg::LANES;

  logic en;
  logic out_valid_r;

  // advance everything unless a finished beat is waiting
  assign en       = out_ready || !out_valid_r;
  assign in_ready = en;

  // stage 1: differences
  plp3_pkg::coord_t p_in [L];
  plp3_pkg::coord_t a_in [L];
  plp3_pkg::coord_t b_in [L];
  plp3_pkg::diff_t  u1_r [L];
  plp3_pkg::diff_t  m1_r [L];
  plp3_pkg::coord_t a1_r [L];
  logic             v1_r;

  assign p_in[0] = in_point_x;
  assign p_in[1] = in_point_y;
  assign p_in[2] = in_point_z;
  assign a_in[0] = in_line_a_x;
  assign a_in[1] = in_line_a_y;
  assign a_in[2] = in_line_a_z;
  assign b_in[0] = in_line_b_x;
  assign b_in[1] = in_line_b_y;
  assign b_in[2] = in_line_b_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        u1_r[i] <= plp3_pkg::DIFF_W'(b_in[i]) - plp3_pkg::DIFF_W'(a_in[i]);
        m1_r[i] <= plp3_pkg::DIFF_W'(p_in[i]) - plp3_pkg::DIFF_W'(a_in[i]);
        a1_r[i] <= a_in[i];
      end
    end
  end

  // stage 2: squares and cross products of magnitudes
  logic [plp3_pkg::MAG_W-1:0] um1  [L];
  logic [plp3_pkg::MAG_W-1:0] mm1  [L];
  logic [plp3_pkg::SQ_W-1:0]  sq2_r [L];
  logic [plp3_pkg::SQ_W-1:0]  pm2_r [L];
  logic                       pn2_r [L];
  logic [plp3_pkg::MAG_W-1:0] um2_r [L];
  logic                       un2_r [L];
  plp3_pkg::coord_t           a2_r  [L];
  logic                       v2_r;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      um1[i] = plp3_pkg::diff_mag(u1_r[i]);
      mm1[i] = plp3_pkg::diff_mag(m1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        sq2_r[i] <= plp3_pkg::SQ_W'(um1[i]) * plp3_pkg::SQ_W'(um1[i]);
        pm2_r[i] <= plp3_pkg::SQ_W'(um1[i]) * plp3_pkg::SQ_W'(mm1[i]);
        pn2_r[i] <= u1_r[i][plp3_pkg::DIFF_W-1] ^ m1_r[i][plp3_pkg::DIFF_W-1];
        um2_r[i] <= um1[i];
        un2_r[i] <= u1_r[i][plp3_pkg::DIFF_W-1];
        a2_r[i]  <= a1_r[i];
      end
    end
  end

  // stage 3: dot products
  logic [plp3_pkg::DEN_W-1:0] den_nxt;
  logic [plp3_pkg::NUM_W-1:0] num_nxt;
  logic [plp3_pkg::NUM_W-1:0] term;
  logic [plp3_pkg::DEN_W-1:0] den3_r;
  logic [plp3_pkg::NUM_W-1:0] num3_r;
  logic [plp3_pkg::MAG_W-1:0] um3_r [L];
  logic                       un3_r [L];
  plp3_pkg::coord_t           a3_r  [L];
  logic                       v3_r;

  always_comb begin
    den_nxt = '0;
    num_nxt = '0;
    term    = '0;
    for (int i = 0; i < L; i++) begin
      den_nxt = den_nxt + plp3_pkg::DEN_W'(sq2_r[i]);
      term    = plp3_pkg::NUM_W'(pm2_r[i]);
      num_nxt = pn2_r[i] ? num_nxt - term : num_nxt + term;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3_r <= den_nxt;
      num3_r <= num_nxt;
      for (int i = 0; i < L; i++) begin
        um3_r[i] <= um2_r[i];
        un3_r[i] <= un2_r[i];
        a3_r[i]  <= a2_r[i];
      end
    end
  end

  // stage 4: |num| times |u_i| as two partial products
  logic                        nneg3;
  logic [plp3_pkg::NUM_W-1:0]  nneg_val;
  logic [plp3_pkg::DEN_W-1:0]  nmag3;
  logic [plp3_pkg::PP_W-1:0]   pl4_r [L];
  logic [plp3_pkg::PP_W-1:0]   ph4_r [L];
  logic [plp3_pkg::DEN_W-1:0]  den4_r;
  plp3_pkg::side_t             side4_r;
  logic                        v4_r;

  assign nneg3    = num3_r[plp3_pkg::NUM_W-1];
  assign nneg_val = -num3_r;
  assign nmag3    = nneg3 ? nneg_val[plp3_pkg::DEN_W-1:0]
                          : num3_r[plp3_pkg::DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        pl4_r[i] <= plp3_pkg::PP_W'(nmag3[plp3_pkg::HALF_W-1:0])
                    * plp3_pkg::PP_W'(um3_r[i]);
        ph4_r[i] <= plp3_pkg::PP_W'(nmag3[plp3_pkg::DEN_W-1:plp3_pkg::HALF_W])
                    * plp3_pkg::PP_W'(um3_r[i]);
      end
      den4_r        <= den3_r;
      side4_r.ax    <= a3_r[0];
      side4_r.ay    <= a3_r[1];
      side4_r.az    <= a3_r[2];
      side4_r.uneg  <= {un3_r[2], un3_r[1], un3_r[0]};
      side4_r.nneg  <= nneg3;
      side4_r.degen <= (den3_r == '0);
    end
  end

  // stage 5: join partial products
  logic [plp3_pkg::PROD_W-1:0] prod5_r [L];
  logic [plp3_pkg::DEN_W-1:0]  den5_r;
  plp3_pkg::side_t             side5_r;
  logic                        v5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        prod5_r[i] <= plp3_pkg::PROD_W'(pl4_r[i])
                      + (plp3_pkg::PROD_W'(ph4_r[i]) << plp3_pkg::HALF_W);
      end
      den5_r  <= den4_r;
      side5_r <= side4_r;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // quotient pipeline
  logic                        dv_vld;
  logic [plp3_pkg::Q_W-1:0]    dv_q   [L];
  logic [plp3_pkg::DEN_W-1:0]  dv_rem [L];
  logic [plp3_pkg::DEN_W-1:0]  dv_den;
  plp3_pkg::side_t             dv_side;

  plp3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v5_r),
    .in_prod  (prod5_r),
    .in_den   (den5_r),
    .in_side  (side5_r),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_rem  (dv_rem),
    .out_den  (dv_den),
    .out_side (dv_side)
  );

  // round, apply to A, saturate
  plp3_pkg::coord_t                a_fin   [L];
  logic [plp3_pkg::Q_W:0]          qr      [L];
  logic signed [plp3_pkg::RES_W-1:0] res   [L];
  plp3_pkg::coord_t                sat_nxt [L];
  logic [L-1:0]                    clip;
  plp3_pkg::coord_t                proj_r  [L];
  logic                            degen_r;
  logic                            ovf_r;

  localparam logic signed [plp3_pkg::RES_W-1:0] RES_MAX =
    plp3_pkg::RES_W'({1'b0, {(plp3_pkg::COORD_W-1){1'b1}}});
  localparam logic signed [plp3_pkg::RES_W-1:0] RES_MIN = -RES_MAX - 1;

  assign a_fin[0] = dv_side.ax;
  assign a_fin[1] = dv_side.ay;
  assign a_fin[2] = dv_side.az;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      qr[i] = (plp3_pkg::Q_W + 1)'(dv_q[i])
            + (plp3_pkg::Q_W + 1)'({dv_rem[i], 1'b0} >= {1'b0, dv_den});
      res[i] = (dv_side.nneg ^ dv_side.uneg[i])
             ? plp3_pkg::RES_W'(a_fin[i]) - $signed({1'b0, qr[i]})
             : plp3_pkg::RES_W'(a_fin[i]) + $signed({1'b0, qr[i]});
      clip[i] = 1'b0;
      if (dv_side.degen) begin
        sat_nxt[i] = a_fin[i];
      end else if (res[i] > RES_MAX) begin
        sat_nxt[i] = plp3_pkg::COORD_W'(RES_MAX);
        clip[i]    = 1'b1;
      end else if (res[i] < RES_MIN) begin
        sat_nxt[i] = plp3_pkg::COORD_W'(RES_MIN);
        clip[i]    = 1'b1;
      end else begin
        sat_nxt[i] = res[i][plp3_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        proj_r[i] <= sat_nxt[i];
      end
      degen_r <= dv_side.degen;
      ovf_r   <= |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_proj_x     = proj_r[0];
  assign out_proj_y     = proj_r[1];
  assign out_proj_z     = proj_r[2];
  assign out_degenerate = degen_r;
  assign out_overflow   = ovf_r;

endmodule

// ===== src/plp3_checker.sv =====
// Port-level checks for point_line_projection_3d, bound to the top level.
// Depends on plp3_pkg for the coordinate type.
module plp3_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_ready,
  input  logic             out_valid,
  input  logic             out_ready,
  input  plp3_pkg::coord_t out_proj_x,
  input  plp3_pkg::coord_t out_proj_y,
  input  plp3_pkg::coord_t out_proj_z,
  input  logic             out_degenerate,
  input  logic             out_overflow
);

  localparam plp3_pkg::coord_t CMAX = {1'b0, {(plp3_pkg::COORD_W-1){1'b1}}};
  localparam plp3_pkg::coord_t CMIN = {1'b1, {(plp3_pkg::COORD_W-1){1'b0}}};

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_proj_x)
      && $stable(out_proj_y) && $stable(out_proj_z)
      && $stable(out_degenerate) && $stable(out_overflow))
    else $error("result beat changed while stalled");

  // an empty output slot never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  // coincident line points never saturate
  a_degen_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_overflow)
    else $error("degenerate beat flagged overflow");

  // overflow only with a coordinate pinned at a limit
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_proj_x == CMAX || out_proj_x == CMIN || out_proj_y == CMAX
      || out_proj_y == CMIN || out_proj_z == CMAX || out_proj_z == CMIN)
    else $error("overflow without a saturated coordinate");

endmodule

bind point_line_projection_3d plp3_checker u_plp3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_proj_x     (out_proj_x),
  .out_proj_y     (out_proj_y),
  .out_proj_z     (out_proj_z),
  .out_degenerate (out_degenerate),
  .out_overflow   (out_overflow)
);
